// ===== rtl/core/eds_pkg.sv =====
package eds_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int VALUE_BITS = 32;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int PW_BITS   = 11;
   localparam int PH_BITS   = 16;
   localparam int COEF_BITS = 32;
   localparam int FRAC_BITS = 30;
   localparam int MIN_DIM   = 3;
   localparam int EMIT_FIRST = 2;

   localparam int WCMP_BITS = (PW_BITS > COL_BITS + 1) ? PW_BITS : COL_BITS + 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PADDED_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_PADDED_HEIGHT = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_X        = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_Y        = CSR_INDEX_BITS'(3);

   // arithmetic widths
   localparam int LAP_BITS     = VALUE_BITS + 3;
   localparam int MAG_BITS     = VALUE_BITS + 2;
   localparam int LO_BITS      = 32;
   localparam int HI_BITS      = (MAG_BITS > LO_BITS) ? MAG_BITS - LO_BITS : 1;
   localparam int PROD_LO_BITS = LO_BITS + COEF_BITS;
   localparam int PROD_HI_BITS = HI_BITS + COEF_BITS;
   localparam int HI_SHIFT     = LO_BITS - FRAC_BITS;
   localparam int RND_BITS     = PROD_LO_BITS - FRAC_BITS + 1;
   localparam int HS_BITS      = PROD_HI_BITS + HI_SHIFT;
   localparam int R_BITS       = ((RND_BITS > HS_BITS) ? RND_BITS : HS_BITS) + 1;
   localparam int SCL_BITS     = R_BITS + 1;
   localparam int SUM_BITS     = SCL_BITS + 2;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic        [VALUE_BITS-1:0] raw_type;
   typedef logic        [COEF_BITS-1:0]  coef_type;
   typedef logic signed [LAP_BITS-1:0]   lap_type;
   typedef logic signed [SCL_BITS-1:0]   scaled_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic        [COL_BITS-1:0]   col_type;
   typedef logic        [PH_BITS-1:0]    row_type;
   typedef logic        [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic        [CSR_DATA_BITS-1:0]  csr_data_type;

endpackage

// ===== rtl/core/eds_if.sv =====
interface eds_req_if;
   import eds_pkg::*;
   logic      valid;
   logic      ready;
   value_type cell_value;
   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

interface eds_rsp_if;
   import eds_pkg::*;
   logic      valid;
   logic      ready;
   value_type new_value;
   logic      last_of_tile;
   modport source (output valid, output new_value, output last_of_tile, input ready);
   modport sink (input valid, input new_value, input last_of_tile, output ready);
endinterface

interface eds_csr_if;
   import eds_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/eds_ram.sv =====
module eds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/eds_cell.sv =====
module eds_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  eds_pkg::value_type  d,
   output eds_pkg::value_type  q
);
   import eds_pkg::*;

   value_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else if (shift) begin
         word_ff <= d;
      end
   end

   assign q = word_ff;
endmodule

// ===== rtl/core/eds_scale.sv =====
module eds_scale (
   input  logic                 clock,
   input  logic                 move,
   input  eds_pkg::lap_type     lap,
   input  eds_pkg::coef_type    coef,
   output eds_pkg::scaled_type  scaled
);
   import eds_pkg::*;

   logic                      neg3_ff;
   logic [MAG_BITS-1:0]       mag3_ff;
   logic                      neg4_ff;
   logic [PROD_LO_BITS-1:0]   plo4_ff;
   logic [PROD_HI_BITS-1:0]   phi4_ff;
   logic                      neg5_ff;
   logic [R_BITS-1:0]         r5_ff;
   scaled_type                scaled6_ff;

   logic [LAP_BITS-1:0]        lap_abs;
   logic [MAG_BITS-1:0]        mag3_in;
   logic [LO_BITS+HI_BITS-1:0] mag_ext;
   logic [PROD_LO_BITS-1:0]    plo4_in;
   logic [PROD_HI_BITS-1:0]    phi4_in;
   logic [RND_BITS:0]          rnd_sum;
   logic [R_BITS-1:0]          r5_in;
   scaled_type                 mag_s;
   scaled_type                 scaled6_in;

   always_comb begin
      lap_abs = lap[LAP_BITS-1] ? LAP_BITS'(-lap) : LAP_BITS'(lap);
      mag3_in = lap_abs[MAG_BITS-1:0];

      mag_ext = (LO_BITS + HI_BITS)'(mag3_ff);
      plo4_in = PROD_LO_BITS'(mag_ext[LO_BITS-1:0]) * PROD_LO_BITS'(coef);
      phi4_in = PROD_HI_BITS'(mag_ext[LO_BITS+HI_BITS-1:LO_BITS]) * PROD_HI_BITS'(coef);

      // round to nearest, ties away from zero on the magnitude
      rnd_sum = {1'b0, plo4_ff[PROD_LO_BITS-1:FRAC_BITS-1]} + (RND_BITS + 1)'(1);
      r5_in   = R_BITS'(rnd_sum[RND_BITS:1]) + (R_BITS'(phi4_ff) << HI_SHIFT);

      mag_s      = $signed({1'b0, r5_ff});
      scaled6_in = neg5_ff ? -mag_s : mag_s;
   end

   always_ff @(posedge clock) begin
      if (move) begin
         neg3_ff    <= lap[LAP_BITS-1];
         mag3_ff    <= mag3_in;
         neg4_ff    <= neg3_ff;
         plo4_ff    <= plo4_in;
         phi4_ff    <= phi4_in;
         neg5_ff    <= neg4_ff;
         r5_ff      <= r5_in;
         scaled6_ff <= scaled6_in;
      end
   end

   assign scaled = scaled6_ff;
endmodule

// ===== rtl/core/explicit_diffusion_stencil_2d.sv =====
// channel | dir | handshake       | payload
// req     | in  | valid / ready   | cell_value
// rsp     | out | valid / ready   | new_value, last_of_tile
// csr     | in  | valid / ready=1 | index, data
//
// one word accepted per cycle while req.ready is high; the word that completes a neighbourhood
// passes the read stage, laplacian, four scaling stages and output register before rsp.valid rises
// the line buffers are read at the accepted column and written back when that word leaves stage 1
// synchronous reset clears counters, valids, configuration and window cells; no clearing pass
// req.ready drops only while the skid entry holds a word; the whole pipeline then holds
// a two-entry output buffer lets req keep flowing while one result waits
module explicit_diffusion_stencil_2d (
   input logic       clock,
   input logic       reset,
   eds_req_if.sink   req,
   eds_rsp_if.source rsp,
   eds_csr_if.sink   csr
);
   import eds_pkg::*;

   localparam int MID_TAPS = 2;

   // configuration
   logic [PW_BITS-1:0] pw_ff;
   logic [PH_BITS-1:0] ph_ff;
   coef_type           coef_x_ff;
   coef_type           coef_y_ff;

   // sequencing
   col_type col_ff, col_in;
   row_type row_ff, row_in;
   logic [WCMP_BITS-1:0] pw_ext, w_eff, w_last;
   row_type h_eff, h_last;
   logic row_end, tile_end, emit0, move, accept;

   // stage 1
   logic      v1_ff;
   logic      emit1_ff;
   logic      last1_ff;
   value_type x1_ff;
   col_type   c1_ff;
   raw_type   upper_rd, mid_rd;
   logic      shift;

   value_type mid_tap [MID_TAPS+1];
   value_type up_c, in_p;
   value_type north, south, east, west, ctr;
   lap_type   lapx_in, lapy_in;

   // stage 2
   logic      v2_ff;
   logic      last2_ff;
   value_type ctr2_ff;
   lap_type   lapx2_ff, lapy2_ff;

   // scaling stages
   logic      v_pipe_ff    [4];
   logic      last_pipe_ff [4];
   value_type ctr_pipe_ff  [4];
   scaled_type scx, scy;

   sum_type   sum;
   value_type result;
   logic      produce;

   // output buffer
   logic      out_valid_ff;
   value_type out_value_ff;
   logic      out_last_ff;
   logic      skid_full_ff;
   value_type skid_value_ff;
   logic      skid_last_ff;

   localparam sum_type SAT_MAX =
      $signed({{(SUM_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}});
   localparam sum_type SAT_MIN = ~SAT_MAX;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff     <= PW_BITS'(MIN_DIM);
         ph_ff     <= PH_BITS'(MIN_DIM);
         coef_x_ff <= '0;
         coef_y_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            REG_PADDED_WIDTH:  pw_ff     <= csr.data[PW_BITS-1:0];
            REG_PADDED_HEIGHT: ph_ff     <= csr.data[PH_BITS-1:0];
            REG_COEF_X:        coef_x_ff <= csr.data[COEF_BITS-1:0];
            REG_COEF_Y:        coef_y_ff <= csr.data[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign move    = !skid_full_ff;
   assign accept  = req.valid && move;
   assign req.ready = move;

   always_comb begin
      pw_ext = WCMP_BITS'(pw_ff);
      if (pw_ext < WCMP_BITS'(MIN_DIM)) begin
         w_eff = WCMP_BITS'(MIN_DIM);
      end else if (pw_ext > WCMP_BITS'(MAX_WIDTH)) begin
         w_eff = WCMP_BITS'(MAX_WIDTH);
      end else begin
         w_eff = pw_ext;
      end
      w_last = w_eff - 1'b1;
      h_eff  = (ph_ff < PH_BITS'(MIN_DIM)) ? PH_BITS'(MIN_DIM) : ph_ff;
      h_last = h_eff - 1'b1;

      row_end  = WCMP_BITS'(col_ff) >= w_last;
      tile_end = row_end && (row_ff >= h_last);
      emit0    = (col_ff >= COL_BITS'(EMIT_FIRST)) && (row_ff >= PH_BITS'(EMIT_FIRST));

      col_in = row_end ? '0 : col_ff + 1'b1;
      row_in = row_end ? (tile_end ? '0 : row_ff + 1'b1) : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line buffer read lands here
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (move) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         emit1_ff <= emit0;
         last1_ff <= tile_end;
         x1_ff    <= req.cell_value;
         c1_ff    <= col_ff;
      end
   end

   assign shift = move && v1_ff;

   eds_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_upper_line (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (c1_ff),
      .wr_data (mid_rd),
      .rd_en   (move),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   eds_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_middle_line (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (c1_ff),
      .wr_data (x1_ff),
      .rd_en   (move),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // window: middle row chain, upper row cell, previous input cell
   assign mid_tap[0] = $signed(mid_rd);

   for (genvar i = 0; i < MID_TAPS; i++) begin : g_mid
      eds_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (mid_tap[i]),
         .q     (mid_tap[i+1])
      );
   end

   eds_cell u_up_cell (
      .clock (clock),
      .reset (reset),
      .shift (shift),
      .d     ($signed(upper_rd)),
      .q     (up_c)
   );

   eds_cell u_in_cell (
      .clock (clock),
      .reset (reset),
      .shift (shift),
      .d     (x1_ff),
      .q     (in_p)
   );

   always_comb begin
      east  = mid_tap[0];
      ctr   = mid_tap[1];
      west  = mid_tap[2];
      north = up_c;
      south = in_p;
      lapx_in = lap_type'(east) + lap_type'(west) - (lap_type'(ctr) <<< 1);
      lapy_in = lap_type'(north) + lap_type'(south) - (lap_type'(ctr) <<< 1);
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (move) begin
         v2_ff <= v1_ff && emit1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         last2_ff <= last1_ff;
         ctr2_ff  <= ctr;
         lapx2_ff <= lapx_in;
         lapy2_ff <= lapy_in;
      end
   end

   eds_scale u_scale_x (
      .clock  (clock),
      .move   (move),
      .lap    (lapx2_ff),
      .coef   (coef_x_ff),
      .scaled (scx)
   );

   eds_scale u_scale_y (
      .clock  (clock),
      .move   (move),
      .lap    (lapy2_ff),
      .coef   (coef_y_ff),
      .scaled (scy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            v_pipe_ff[i] <= 1'b0;
         end
      end else if (move) begin
         v_pipe_ff[0] <= v2_ff;
         for (int i = 1; i < 4; i++) begin
            v_pipe_ff[i] <= v_pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         last_pipe_ff[0] <= last2_ff;
         ctr_pipe_ff[0]  <= ctr2_ff;
         for (int i = 1; i < 4; i++) begin
            last_pipe_ff[i] <= last_pipe_ff[i-1];
            ctr_pipe_ff[i]  <= ctr_pipe_ff[i-1];
         end
      end
   end

   always_comb begin
      sum = sum_type'(ctr_pipe_ff[3]) + sum_type'(scx) + sum_type'(scy);
      priority if (sum > SAT_MAX) begin
         result = SAT_MAX[VALUE_BITS-1:0];
      end else if (sum < SAT_MIN) begin
         result = SAT_MIN[VALUE_BITS-1:0];
      end else begin
         result = sum[VALUE_BITS-1:0];
      end
   end

   assign produce = move && v_pipe_ff[3];

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp.ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (produce) begin
         if (out_valid_ff && !rsp.ready) begin
            skid_full_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp.ready) begin
            out_value_ff <= skid_value_ff;
            out_last_ff  <= skid_last_ff;
         end
      end else if (produce) begin
         if (out_valid_ff && !rsp.ready) begin
            skid_value_ff <= result;
            skid_last_ff  <= last_pipe_ff[3];
         end else begin
            out_value_ff <= result;
            out_last_ff  <= last_pipe_ff[3];
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.new_value    = out_value_ff;
   assign rsp.last_of_tile = out_last_ff;
endmodule
